// ----- rtl/bhq_pkg.sv -----
package bhq_pkg;

    localparam int unsigned ETA_CLASSES = 3;
    localparam int unsigned PT_CLASSES  = 6;
    localparam int unsigned NUM_CLASSES = ETA_CLASSES * PT_CLASSES;
    localparam int unsigned CLS_W       = $clog2(NUM_CLASSES);

    // eta class edges, unsigned 4.12: 0.6, 1.6, 2.5
    localparam logic [15:0] ETA_EDGE_0 = 16'd2458;
    localparam logic [15:0] ETA_EDGE_1 = 16'd6554;
    localparam logic [15:0] ETA_EDGE_2 = 16'd10240;

    // pt class edges, unsigned 8.8: 0.5, 1, 2, 5, 10
    localparam logic [15:0] PT_EDGE_0 = 16'd128;
    localparam logic [15:0] PT_EDGE_1 = 16'd256;
    localparam logic [15:0] PT_EDGE_2 = 16'd512;
    localparam logic [15:0] PT_EDGE_3 = 16'd1280;
    localparam logic [15:0] PT_EDGE_4 = 16'd2560;

    localparam logic [1:0] ETA_NONE = 2'd3;

    localparam logic [1:0] CFG_QFRAC  = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    localparam logic [15:0] QFRAC_RESET  = 16'd62259;
    localparam logic [15:0] OFFSET_RESET = 16'd0;
    localparam logic [23:0] SCALE_RESET  = 24'd1024;

    localparam logic CMD_FILL  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [CLS_W-1:0] t_cls;

    typedef struct packed {
        logic        command;
        logic [15:0] pt;
        logic [15:0] abs_eta;
        logic        reference_valid;
        logic [15:0] sample_value;
        logic [1:0]  query_eta_bin;
        logic [2:0]  query_pt_bin;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [9:0]  quantile_bin;
        logic [31:0] class_total;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FMUL,
        ST_FRD,
        ST_FWR,
        ST_QMUL,
        ST_QSCAN,
        ST_RESP
    } t_state;

    function automatic logic [1:0] eta_class(input logic [15:0] eta);
        logic [1:0] c;
        priority if (eta < ETA_EDGE_0) c = 2'd0;
        else if (eta < ETA_EDGE_1)     c = 2'd1;
        else if (eta < ETA_EDGE_2)     c = 2'd2;
        else                           c = ETA_NONE;
        return c;
    endfunction

    function automatic logic [2:0] pt_class(input logic [15:0] pt);
        logic [2:0] c;
        priority if (pt < PT_EDGE_0) c = 3'd0;
        else if (pt < PT_EDGE_1)     c = 3'd1;
        else if (pt < PT_EDGE_2)     c = 3'd2;
        else if (pt < PT_EDGE_3)     c = 3'd3;
        else if (pt < PT_EDGE_4)     c = 3'd4;
        else                         c = 3'd5;
        return c;
    endfunction

    function automatic t_cls class_index(input logic [1:0] e, input logic [2:0] p);
        return CLS_W'(e) * CLS_W'(PT_CLASSES) + CLS_W'(p);
    endfunction

endpackage

// ----- rtl/bhq_bin_store.sv -----
module bhq_bin_store #(
    parameter int DEPTH  = 18432,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_clearing
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              r_clearing;
    logic              n_clearing;

    // sweep zeros through every entry after reset
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ----- rtl/binned_histogram_quantile_core.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (bhq_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (bhq_pkg::t_out_item)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Fill: accept, multiply, bin memory read, write-back; a dropped sample skips the write-back.
// Query: accept, multiply, scan, response; an empty class skips the scan, which
//   walks the class in order through the single read port of the bin memory.
// Reset: a clearing pass over all 18 * NUM_BINS entries zeroes the bin memory; no
//   transaction is accepted on the input channel until it ends.
// The output register holds a result while the next item is accepted; a query
//   result waits in its last state only if the output register is still full.
module binned_histogram_quantile_core #(
    parameter int NUM_BINS    = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bhq_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bhq_pkg::t_out_item   o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    import bhq_pkg::*;

    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DEPTH  = NUM_CLASSES * NUM_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = COUNT_WIDTH;
    localparam int TGT_W  = CW + 16;

    localparam logic [CW-1:0] COUNT_MAX = '1;

    t_state r_state;
    t_state n_state;

    logic [15:0] r_qfrac;
    logic [15:0] r_offset;
    logic [23:0] r_scale;

    logic [CW-1:0] r_totals [NUM_CLASSES];

    t_cls           r_cls;
    logic           r_keep;
    logic           r_qvalid;
    logic [15:0]    r_diff;
    logic           r_bin_ok;
    logic [BIN_W-1:0] r_bin;
    logic [ADDR_W-1:0] r_base;
    logic [CW-1:0]  r_total;
    logic [TGT_W-1:0] r_target;
    logic [CW:0]    r_cum;
    logic [BIN_W:0] r_issue_cnt;
    logic           r_rd_pending;
    logic [BIN_W-1:0] r_rd_bin;
    logic           r_res_found;
    logic [BIN_W-1:0] r_res_bin;
    logic [CW-1:0]  r_res_total;
    logic           r_out_valid;
    t_out_item      r_out_item;

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CW-1:0]     mem_wr_data;
    logic [CW-1:0]     mem_rd_data;
    logic              mem_clearing;

    logic              in_fire;
    logic              out_free;
    logic [39:0]       prod;
    logic [23:0]       bin_full;
    logic [CW-1:0]     sel_total;
    logic [CW:0]       sum;
    logic              hit;
    logic              last_bin;
    logic              can_issue;
    logic [1:0]        in_eta_cls;

    bhq_bin_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (CW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (mem_rd_en),
        .i_rd_addr  (mem_rd_addr),
        .i_wr_en    (mem_wr_en),
        .i_wr_addr  (mem_wr_addr),
        .i_wr_data  (mem_wr_data),
        .o_rd_data  (mem_rd_data),
        .o_clearing (mem_clearing)
    );

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_eta_cls = eta_class(i_in_item.abs_eta);
    assign prod       = 40'(r_diff) * 40'(r_scale);
    assign bin_full   = prod[39:16];
    assign sel_total  = r_qvalid ? r_totals[r_cls] : '0;
    assign sum        = r_cum + (CW+1)'(mem_rd_data);
    assign hit        = (sum >= {1'b0, r_total}) ||
                        ({sum, 16'b0} >= {1'b0, r_target});
    assign last_bin   = (r_rd_bin == BIN_W'(NUM_BINS - 1));
    assign can_issue  = (r_issue_cnt < (BIN_W+1)'(NUM_BINS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (!mem_clearing) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in_item.command == CMD_QUERY) ? ST_QMUL : ST_FMUL;
                end
            end
            ST_FMUL: n_state = ST_FRD;
            ST_FRD:  n_state = r_bin_ok ? ST_FWR : ST_IDLE;
            ST_FWR:  n_state = ST_IDLE;
            ST_QMUL: begin
                n_state = (sel_total == '0) ? ST_RESP : ST_QSCAN;
            end
            ST_QSCAN: begin
                if (r_rd_pending && (hit || last_bin)) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_ready  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_base + ADDR_W'(r_bin);
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_base + ADDR_W'(r_bin);
        mem_wr_data = (mem_rd_data == COUNT_MAX) ? mem_rd_data : mem_rd_data + 1'b1;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_FRD:   mem_rd_en  = r_bin_ok;
            ST_FWR:   mem_wr_en  = 1'b1;
            ST_QSCAN: begin
                mem_rd_en   = can_issue;
                mem_rd_addr = r_base + ADDR_W'(r_issue_cnt[BIN_W-1:0]);
            end
            ST_CLEAR, ST_FMUL, ST_QMUL, ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qfrac  <= QFRAC_RESET;
            r_offset <= OFFSET_RESET;
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_QFRAC)  r_qfrac  <= i_cfg_data[15:0];
            if (i_cfg_index == CFG_OFFSET) r_offset <= i_cfg_data[15:0];
            if (i_cfg_index == CFG_SCALE)  r_scale  <= i_cfg_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_out_valid  <= 1'b0;
            r_rd_pending <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) r_totals[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_pending <= (r_state == ST_QSCAN) && can_issue;
            if (r_state == ST_FWR && r_totals[r_cls] != COUNT_MAX) begin
                r_totals[r_cls] <= r_totals[r_cls] + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_item.command == CMD_QUERY) begin
                    r_qvalid <= (i_in_item.query_eta_bin < 2'(ETA_CLASSES)) &&
                                (i_in_item.query_pt_bin < 3'(PT_CLASSES));
                    r_cls    <= class_index(i_in_item.query_eta_bin,
                                            i_in_item.query_pt_bin);
                end else begin
                    r_keep <= i_in_item.reference_valid && (in_eta_cls != ETA_NONE) &&
                              (i_in_item.sample_value >= r_offset);
                    r_cls  <= class_index(in_eta_cls, pt_class(i_in_item.pt));
                    r_diff <= i_in_item.sample_value - r_offset;
                end
            end
            ST_FMUL: begin
                r_bin_ok <= r_keep && (bin_full < 24'(NUM_BINS));
                r_bin    <= bin_full[BIN_W-1:0];
                r_base   <= ADDR_W'(r_cls) * ADDR_W'(NUM_BINS);
            end
            ST_QMUL: begin
                r_total     <= sel_total;
                r_target    <= TGT_W'(r_qfrac) * TGT_W'(sel_total);
                r_base      <= ADDR_W'(r_cls) * ADDR_W'(NUM_BINS);
                r_cum       <= '0;
                r_issue_cnt <= '0;
                r_res_found <= 1'b0;
                r_res_bin   <= '0;
                r_res_total <= sel_total;
            end
            ST_QSCAN: begin
                if (can_issue) begin
                    r_issue_cnt <= r_issue_cnt + 1'b1;
                    r_rd_bin    <= r_issue_cnt[BIN_W-1:0];
                end
                if (r_rd_pending) begin
                    r_cum <= sum;
                    if (hit) begin
                        r_res_found <= 1'b1;
                        r_res_bin   <= r_rd_bin;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    r_out_item.found        <= r_res_found;
                    r_out_item.quantile_bin <= 10'(r_res_bin);
                    r_out_item.class_total  <= 32'(r_res_total);
                end
            end
            ST_CLEAR, ST_FRD, ST_FWR: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QSCAN) |-> !mem_wr_en)
        else $error("bin memory written during a query scan");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("output loaded outside the response state");

    a_cum_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QSCAN) |-> (r_cum < {1'b0, r_total}))
        else $error("running sum passed the class total without a hit");

    a_rmw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWR) |-> ($past(mem_rd_en) && ($past(mem_rd_addr) == mem_wr_addr)))
        else $error("write-back address differs from the entry read");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import bhq_pkg::*;

    localparam int BINS        = 1024;
    localparam int HOLD_CYCLES = 500;
    localparam int LIMIT       = 8_000_000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // histogram mirror and register copies
    bit [31:0] bin_tally   [NUM_CLASSES*BINS];
    bit [31:0] class_tally [NUM_CLASSES];
    logic [15:0] m_qfrac  = QFRAC_RESET;
    logic [15:0] m_offset = OFFSET_RESET;
    logic [23:0] m_scale  = SCALE_RESET;

    t_out_item pending_answers[$];
    int  mismatches = 0;
    int  cycles     = 0;
    bit  quiet      = 1'b0;
    bit  hold_off   = 1'b0;
    bit  holding    = 1'b0;

    always #4 clk = ~clk;

    binned_histogram_quantile_core #(
        .NUM_BINS    (BINS),
        .COUNT_WIDTH (32)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // fold one accepted transaction into the mirror, queue the answer of a query
    task automatic histogram_accept(input t_in_item it);
        int cls;
        int ec;
        int pc;
        int b;
        logic [63:0] bin;
        logic [63:0] target;
        logic [63:0] cum;
        t_out_item ans;
        if (it.command == CMD_FILL) begin
            if (!it.reference_valid || it.abs_eta >= ETA_EDGE_2) return;
            ec = (it.abs_eta < ETA_EDGE_0) ? 0 : (it.abs_eta < ETA_EDGE_1) ? 1 : 2;
            if (it.pt < PT_EDGE_0)      pc = 0;
            else if (it.pt < PT_EDGE_1) pc = 1;
            else if (it.pt < PT_EDGE_2) pc = 2;
            else if (it.pt < PT_EDGE_3) pc = 3;
            else if (it.pt < PT_EDGE_4) pc = 4;
            else                        pc = 5;
            if (it.sample_value < m_offset) return;
            bin = ((64'(it.sample_value) - 64'(m_offset)) * 64'(m_scale)) >> 16;
            if (bin >= 64'(BINS)) return;
            cls = ec * PT_CLASSES + pc;
            if (bin_tally[cls*BINS + int'(bin)] != '1) bin_tally[cls*BINS + int'(bin)]++;
            if (class_tally[cls] != '1) class_tally[cls]++;
            return;
        end
        ans = '0;
        if (it.query_eta_bin < ETA_CLASSES && it.query_pt_bin < PT_CLASSES) begin
            cls = int'(it.query_eta_bin) * PT_CLASSES + int'(it.query_pt_bin);
            ans.class_total = class_tally[cls];
            if (class_tally[cls] != 0) begin
                target = 64'(m_qfrac) * 64'(class_tally[cls]);
                cum = '0;
                for (b = 0; b < BINS; b++) begin
                    cum += 64'(bin_tally[cls*BINS + b]);
                    if (cum >= 64'(class_tally[cls]) || (cum << 16) >= target) begin
                        ans.found        = 1'b1;
                        ans.quantile_bin = b[9:0];
                        break;
                    end
                end
            end
        end
        pending_answers.push_back(ans);
    endtask

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) histogram_accept(in_item);
    end

    always @(posedge clk) begin : check_answers
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", 64'(out_item), '0);
            end else begin
                want = pending_answers.pop_front();
                if (out_item.found !== want.found)
                    report_mismatch("found", 64'(out_item.found), 64'(want.found));
                if (out_item.quantile_bin !== want.quantile_bin)
                    report_mismatch("quantile_bin", 64'(out_item.quantile_bin),
                                    64'(want.quantile_bin));
                if (out_item.class_total !== want.class_total)
                    report_mismatch("class_total", 64'(out_item.class_total),
                                    64'(want.class_total));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d answers pending", cycles,
                     pending_answers.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : drive_out_ready
        int span;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                holding  = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end else begin
                span = pick_gap();
                if (span > 0) begin
                    out_ready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait for every answer, then let a trailing fill finish
    task automatic drain_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QFRAC:  m_qfrac  = data[15:0];
            CFG_OFFSET: m_offset = data[15:0];
            CFG_SCALE:  m_scale  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] qfrac, input logic [15:0] offset,
                              input logic [23:0] scale);
        drain_block();
        write_reg(CFG_QFRAC, 24'(qfrac));
        write_reg(CFG_OFFSET, 24'(offset));
        write_reg(CFG_SCALE, scale);
    endtask

    function automatic t_in_item fill_item(input logic [15:0] pt, input logic [15:0] eta,
                                           input logic refv, input logic [15:0] value);
        t_in_item it;
        it = '0;
        it.command         = CMD_FILL;
        it.pt              = pt;
        it.abs_eta         = eta;
        it.reference_valid = refv;
        it.sample_value    = value;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic [1:0] e, input logic [2:0] p);
        t_in_item it;
        it = '0;
        it.command       = CMD_QUERY;
        it.query_eta_bin = e;
        it.query_pt_bin  = p;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        logic [63:0] lim;
        logic [63:0] span;
        it.command         = CMD_FILL;
        it.pt              = 16'($urandom());
        it.abs_eta         = 16'($urandom());
        it.reference_valid = 1'($urandom());
        it.sample_value    = 16'($urandom());
        it.query_eta_bin   = 2'($urandom());
        it.query_pt_bin    = 3'($urandom());
        if ($urandom_range(0, 99) < 12) begin
            it.command = CMD_QUERY;
            if ($urandom_range(0, 19) != 0) begin
                it.query_eta_bin = 2'($urandom_range(0, ETA_CLASSES - 1));
                it.query_pt_bin  = 3'($urandom_range(0, PT_CLASSES - 1));
            end
            return it;
        end
        it.reference_valid = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 9) != 0) it.abs_eta = 16'($urandom_range(0, 10239));
        if ($urandom_range(0, 3) != 0) it.pt = 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 9) != 0) begin
            // aim at the bin window, one step past it now and then
            lim  = 64'(16'hFFFF - m_offset);
            span = (m_scale == 0) ? lim
                 : ((64'(BINS) << 16) + 64'(m_scale) - 1) / 64'(m_scale);
            if (span > lim) span = lim;
            it.sample_value = m_offset + 16'($urandom_range(0, 32'(span)));
        end
        return it;
    endfunction

    task automatic test_class_edges();
        send_item(query_item(2'd0, 3'd0));
        send_item(query_item(2'd3, 3'd0));
        send_item(query_item(2'd0, 3'd6));
        send_item(query_item(2'd3, 3'd7));
        send_item(fill_item(16'd0, 16'd0, 1'b1, 16'd0));
        send_item(fill_item(16'hFFFF, 16'd0, 1'b1, 16'hFFFF));
        send_item(fill_item(16'd127, 16'd2457, 1'b1, 16'd100));
        send_item(fill_item(16'd128, 16'd2458, 1'b1, 16'd200));
        send_item(fill_item(16'd255, 16'd6553, 1'b1, 16'd300));
        send_item(fill_item(16'd256, 16'd6554, 1'b1, 16'd400));
        send_item(fill_item(16'd511, 16'd10239, 1'b1, 16'd500));
        send_item(fill_item(16'd512, 16'd10239, 1'b1, 16'd600));
        send_item(fill_item(16'd1279, 16'd0, 1'b1, 16'd700));
        send_item(fill_item(16'd1280, 16'd0, 1'b1, 16'd800));
        send_item(fill_item(16'd2559, 16'd6554, 1'b1, 16'd900));
        send_item(fill_item(16'd2560, 16'd6554, 1'b1, 16'd1000));
        // drop: eta at the outer edge, eta maximum, no reference
        send_item(fill_item(16'd300, 16'd10240, 1'b1, 16'd5));
        send_item(fill_item(16'd300, 16'hFFFF, 1'b1, 16'd5));
        send_item(fill_item(16'd300, 16'd0, 1'b0, 16'd5));
        send_item(query_item(2'd0, 3'd0));
        send_item(query_item(2'd0, 3'd5));
        send_item(query_item(2'd2, 3'd2));
    endtask

    task automatic test_value_window();
        set_config(16'd32768, 16'd1000, 24'h010000);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_item(fill_item(16'd0, 16'd0, 1'b1, 16'd999));
        send_item(fill_item(16'd0, 16'd0, 1'b1, 16'd2024));
        send_item(fill_item(16'd0, 16'd0, 1'b1, 16'd2023));
        send_item(fill_item(16'd0, 16'd0, 1'b1, 16'd1000));
        send_item(query_item(2'd0, 3'd0));
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) send_item(random_item());
    endtask

    // long receiver hold-off: results back up until the input stalls
    task automatic test_output_stall();
        int n;
        drain_block();
        hold_off = 1'b1;
        while (!holding) @(posedge clk);
        quiet = 1'b1;
        for (n = 0; n < 16; n++)
            send_item((n % 3 == 0) ? query_item(2'($urandom_range(0, 2)),
                                                3'($urandom_range(0, 5)))
                                   : random_item());
        quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_class_edges();
        test_value_window();
        set_config(QFRAC_RESET, 16'd0, 24'd1024);
        test_random_traffic(450);
        test_output_stall();
        set_config(16'd0, 16'd0, 24'hFFFFFF);
        test_random_traffic(250);
        set_config(16'hFFFF, 16'hFFFF, 24'd0);
        test_random_traffic(150);
        set_config(16'd1, 16'd30000, 24'd70000);
        quiet = 1'b1;
        test_random_traffic(400);
        quiet = 1'b0;
        set_config(16'd40000, 16'd123, 24'd300);
        test_random_traffic(480);
        drain_block();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
